[hw/rtl/assert_macros.svh]
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// Same-cycle implication.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication failed");

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");

`endif

[hw/rtl/hsv2rgb_pkg.sv]
// Types and constants for the HSV to RGB converter.
`timescale 1ns / 1ps
package hsv2rgb_pkg;

  localparam int unsigned HUE_FULL    = 360;
  localparam int unsigned SECTOR_DEG  = 60;
  localparam int unsigned PCT_FULL    = 100;
  localparam int unsigned CHAN_MAX    = 255;
  // common denominator for every channel: 60 * 100 * 100
  localparam int unsigned DEN         = SECTOR_DEG * PCT_FULL * PCT_FULL;
  localparam int unsigned SECTOR_FULL = SECTOR_DEG * PCT_FULL;

  localparam int unsigned SCALE_W     = 13;  // holds up to 6000
  localparam int unsigned MUL_W       = 20;  // val * scale, up to 600000
  localparam int unsigned NUM_W       = 28;  // times 255
  localparam int unsigned REM_W       = 21;  // below 2 * DEN
  localparam int unsigned RECIP_SHIFT = 48;
  localparam int unsigned RECIP_W     = 29;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'((64'd1 << RECIP_SHIFT) / DEN);

  localparam int unsigned PIPE_DEPTH  = 7;

  typedef struct packed {
    logic [8:0] hue;
    logic [6:0] saturation;
    logic [6:0] brightness;
  } hsv_in_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_out_t;

  typedef enum logic [2:0] {
    SEC_0 = 3'd0,
    SEC_1 = 3'd1,
    SEC_2 = 3'd2,
    SEC_3 = 3'd3,
    SEC_4 = 3'd4,
    SEC_5 = 3'd5
  } sector_t;

  // per-channel scale factors, out of SECTOR_FULL
  typedef struct packed {
    logic [SCALE_W-1:0] red;
    logic [SCALE_W-1:0] green;
    logic [SCALE_W-1:0] blue;
  } chan_scale_t;

  typedef struct packed {
    logic advance;    // whole pipe moves this cycle
    logic rem_valid;  // remainder stage holds a live item
  } pipe_ctl_t;

endpackage

[hw/rtl/hsv2rgb_sector.sv]
// Stages 1-2: hue wrap, sector split and per-channel scale selection.
`timescale 1ns / 1ps
module hsv2rgb_sector (
  input  logic                      clk,
  input  hsv2rgb_pkg::pipe_ctl_t    ctl,
  input  hsv2rgb_pkg::hsv_in_t      in_data,
  output hsv2rgb_pkg::chan_scale_t  scale,
  output logic [6:0]                val
);
  import hsv2rgb_pkg::*;

  // stage 1
  sector_t      sector_r, sector_nxt;
  logic [5:0]   rem_r, rem_nxt;
  logic [6:0]   sat_r, sat_nxt;
  logic [6:0]   val1_r, val1_nxt;
  // stage 2
  chan_scale_t  scale_r, scale_nxt;
  logic [6:0]   val2_r;

  logic [8:0]   hue_w;
  logic [8:0]   base;

  always_comb begin
    hue_w = (in_data.hue >= 9'(HUE_FULL)) ? in_data.hue - 9'(HUE_FULL) : in_data.hue;
    if (hue_w < 9'(SECTOR_DEG)) begin
      sector_nxt = SEC_0;
      base       = 9'd0;
    end else if (hue_w < 9'(2 * SECTOR_DEG)) begin
      sector_nxt = SEC_1;
      base       = 9'(SECTOR_DEG);
    end else if (hue_w < 9'(3 * SECTOR_DEG)) begin
      sector_nxt = SEC_2;
      base       = 9'(2 * SECTOR_DEG);
    end else if (hue_w < 9'(4 * SECTOR_DEG)) begin
      sector_nxt = SEC_3;
      base       = 9'(3 * SECTOR_DEG);
    end else if (hue_w < 9'(5 * SECTOR_DEG)) begin
      sector_nxt = SEC_4;
      base       = 9'(4 * SECTOR_DEG);
    end else begin
      sector_nxt = SEC_5;
      base       = 9'(5 * SECTOR_DEG);
    end
    rem_nxt  = 6'(hue_w - base);
    sat_nxt  = (in_data.saturation > 7'(PCT_FULL)) ? 7'(PCT_FULL) : in_data.saturation;
    val1_nxt = (in_data.brightness > 7'(PCT_FULL)) ? 7'(PCT_FULL) : in_data.brightness;
  end

  logic [SCALE_W-1:0] sat_w, rem_w;
  logic [SCALE_W-1:0] a_v, a_p, a_q, a_t;

  always_comb begin
    sat_w = SCALE_W'(sat_r);
    rem_w = SCALE_W'(rem_r);
    a_v   = SCALE_W'(SECTOR_FULL);
    a_p   = SCALE_W'((SCALE_W'(PCT_FULL) - sat_w) * SCALE_W'(SECTOR_DEG));
    a_q   = SCALE_W'(SECTOR_FULL) - SCALE_W'(rem_w * sat_w);
    a_t   = SCALE_W'(SECTOR_FULL) - SCALE_W'((SCALE_W'(SECTOR_DEG) - rem_w) * sat_w);
    case (sector_r)
      SEC_0: begin
        scale_nxt = '{red: a_v, green: a_t, blue: a_p};
      end
      SEC_1: begin
        scale_nxt = '{red: a_q, green: a_v, blue: a_p};
      end
      SEC_2: begin
        scale_nxt = '{red: a_p, green: a_v, blue: a_t};
      end
      SEC_3: begin
        scale_nxt = '{red: a_p, green: a_q, blue: a_v};
      end
      SEC_4: begin
        scale_nxt = '{red: a_t, green: a_p, blue: a_v};
      end
      default: begin
        scale_nxt = '{red: a_v, green: a_p, blue: a_q};
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.advance) begin
      sector_r <= sector_nxt;
      rem_r    <= rem_nxt;
      sat_r    <= sat_nxt;
      val1_r   <= val1_nxt;
      scale_r  <= scale_nxt;
      val2_r   <= val1_r;
    end
  end

  assign scale = scale_r;
  assign val   = val2_r;

endmodule

[hw/rtl/hsv2rgb_scale.sv]
// Stages 3-4: one channel's numerator, val * scale * 255.
`timescale 1ns / 1ps
module hsv2rgb_scale (
  input  logic                               clk,
  input  hsv2rgb_pkg::pipe_ctl_t             ctl,
  input  logic [hsv2rgb_pkg::SCALE_W-1:0]    scale,
  input  logic [6:0]                         val,
  output logic [hsv2rgb_pkg::NUM_W-1:0]      num
);
  import hsv2rgb_pkg::*;

  logic [MUL_W-1:0] prod_r, prod_nxt;
  logic [NUM_W-1:0] num_r, num_nxt;

  always_comb begin
    prod_nxt = MUL_W'(val) * MUL_W'(scale);
    // x * 255 as x * 256 - x
    num_nxt  = (NUM_W'(prod_r) << 8) - NUM_W'(prod_r);
  end

  always_ff @(posedge clk) begin
    if (ctl.advance) begin
      prod_r <= prod_nxt;
      num_r  <= num_nxt;
    end
  end

  assign num = num_r;

endmodule

[hw/rtl/hsv2rgb_cdiv.sv]
// Stages 5-7: floor division by the common denominator via reciprocal.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module hsv2rgb_cdiv (
  input  logic                           clk,
  input  logic                           rst_n,
  input  hsv2rgb_pkg::pipe_ctl_t         ctl,
  input  logic [hsv2rgb_pkg::NUM_W-1:0]  num,
  output logic [7:0]                     quo
);
  import hsv2rgb_pkg::*;

  localparam int unsigned PROD_W = NUM_W + RECIP_W;

  // stage 5
  logic [PROD_W-1:0] prod_r, prod_nxt;
  logic [NUM_W-1:0]  num_r;
  // stage 6
  logic [7:0]        q0_r, q0_nxt;
  logic [REM_W-1:0]  rem_r, rem_nxt;
  // stage 7
  logic [7:0]        quo_r, quo_nxt;

  logic [NUM_W-1:0]  back;

  always_comb begin
    prod_nxt = PROD_W'(num) * PROD_W'(RECIP);
    // estimate is exact or one low
    q0_nxt   = prod_r[RECIP_SHIFT +: 8];
    back     = NUM_W'(NUM_W'(q0_nxt) * NUM_W'(DEN));
    rem_nxt  = REM_W'(num_r - back);
    quo_nxt  = (rem_r >= REM_W'(DEN)) ? q0_r + 8'd1 : q0_r;
  end

  always_ff @(posedge clk) begin
    if (ctl.advance) begin
      prod_r <= prod_nxt;
      num_r  <= num;
      q0_r   <= q0_nxt;
      rem_r  <= rem_nxt;
      quo_r  <= quo_nxt;
    end
  end

  assign quo = quo_r;

  `ASSERT_IMPLIES(a_rem_bound, clk, rst_n, ctl.rem_valid, rem_r < REM_W'(2 * DEN))
  `ASSERT_IMPLIES(a_no_wrap, clk, rst_n, ctl.rem_valid && (rem_r >= REM_W'(DEN)), q0_r != 8'hFF)

endmodule

[hw/rtl/hsv_to_rgb_converter_core.sv]
// Top level of the HSV to RGB converter pipeline.
`timescale 1ns / 1ps
`include "assert_macros.svh"
// Usage:
//  - Input channel in_valid / in_stall / in_data carries hue (degrees),
//    saturation and brightness (percent). A transfer happens on a rising
//    edge with in_valid high and in_stall low.
//  - Output channel out_valid / out_stall / out_data carries 8-bit red,
//    green and blue, one result per input transfer, in order.
//  - Hue of 360 or more wraps once; saturation and brightness above 100
//    are clamped to 100.
//  - Throughput: one item per cycle while no valid result is stalled by
//    the receiver; the seven register stages all move together, so the
//    figure is set by the single shared pipe-advance.
//  - Stages: 1 hue wrap and sector, 2 scale select, 3 multiply by value,
//    4 times 255, 5 reciprocal multiply, 6 remainder, 7 correction.
//  - When the receiver stalls a valid result, the whole pipe holds and
//    in_stall goes high in the same cycle; nothing is dropped or repeated.
//  - Reset (rst_n low, synchronous) clears all stage valid bits; payload
//    registers are not reset. No clearing pass; input is taken right away.
module hsv_to_rgb_converter_core (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  hsv2rgb_pkg::hsv_in_t   in_data,
  output logic                   out_valid,
  input  logic                   out_stall,
  output hsv2rgb_pkg::rgb_out_t  out_data
);
  import hsv2rgb_pkg::*;

  logic [PIPE_DEPTH-1:0] valid_r, valid_nxt;
  logic                  advance;
  pipe_ctl_t             ctl;

  chan_scale_t           scale;
  logic [6:0]            val;
  logic [NUM_W-1:0]      num_red, num_green, num_blue;

  // pipe holds only while a finished result waits on the receiver
  assign advance       = !(valid_r[PIPE_DEPTH-1] && out_stall);
  assign ctl.advance   = advance;
  assign ctl.rem_valid = valid_r[PIPE_DEPTH-2];
  assign in_stall      = !advance;
  assign out_valid     = valid_r[PIPE_DEPTH-1];

  assign valid_nxt = {valid_r[PIPE_DEPTH-2:0], in_valid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (advance) begin
      valid_r <= valid_nxt;
    end
  end

  hsv2rgb_sector u_sector (
    .clk     (clk),
    .ctl     (ctl),
    .in_data (in_data),
    .scale   (scale),
    .val     (val)
  );

  hsv2rgb_scale u_scale_red (
    .clk   (clk),
    .ctl   (ctl),
    .scale (scale.red),
    .val   (val),
    .num   (num_red)
  );

  hsv2rgb_scale u_scale_green (
    .clk   (clk),
    .ctl   (ctl),
    .scale (scale.green),
    .val   (val),
    .num   (num_green)
  );

  hsv2rgb_scale u_scale_blue (
    .clk   (clk),
    .ctl   (ctl),
    .scale (scale.blue),
    .val   (val),
    .num   (num_blue)
  );

  hsv2rgb_cdiv u_cdiv_red (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ctl),
    .num   (num_red),
    .quo   (out_data.red)
  );

  hsv2rgb_cdiv u_cdiv_green (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ctl),
    .num   (num_green),
    .quo   (out_data.green)
  );

  hsv2rgb_cdiv u_cdiv_blue (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ctl),
    .num   (num_blue),
    .quo   (out_data.blue)
  );

  // a held pipe keeps every stage's occupancy
  `ASSERT_NEXT(a_valid_hold, clk, rst_n, !advance, $stable(valid_r))

endmodule

[tb/sv/hsv_to_rgb_converter_core_test.sv]
// Testbench for the HSV to RGB converter core: every pixel transfer is predicted and checked.
`timescale 1ns / 1ps
module hsv_to_rgb_converter_core_test;
  import hsv2rgb_pkg::*;

  // No transfer on either channel for this many cycles means the block is hung.
  localparam int unsigned STUCK_LIMIT  = 4000;
  // Length of the long receiver hold-off; well under STUCK_LIMIT.
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned PRINT_CAP    = 100;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  hsv_in_t  in_data = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  rgb_out_t out_data;

  // Pixels predicted at input transfer, oldest first.
  rgb_out_t    rgb_pending[$];
  int unsigned mismatch_count = 0;
  int unsigned stuck_cycles = 0;

  // Idle percentages. send_idle_pct is read only by the stimulus process.
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;

  // Hold-off handshake between the stimulus and the receiver process:
  // each bump of hold_asks starts one long stall.
  int unsigned hold_asks = 0;
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;

  hsv_to_rgb_converter_core DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Exact integer HSV to RGB: hue wraps once (9 bits never reach 720),
  // percentages clamp at 100, every channel is a floor of the scaled ratio.
  function automatic rgb_out_t hsv_pixel_to_rgb(hsv_in_t px);
    int unsigned hue_deg, sat_pct, val_pct, frac_deg;
    int unsigned lvl_v, lvl_p, lvl_q, lvl_t;
    sector_t     sec;
    rgb_out_t    pix;
    hue_deg = px.hue;
    if (hue_deg >= HUE_FULL) begin
      hue_deg = hue_deg - HUE_FULL;
    end
    sat_pct = (px.saturation > PCT_FULL) ? PCT_FULL : px.saturation;
    val_pct = (px.brightness > PCT_FULL) ? PCT_FULL : px.brightness;
    sec      = sector_t'(hue_deg / SECTOR_DEG);
    frac_deg = hue_deg % SECTOR_DEG;

    lvl_v = (val_pct * CHAN_MAX) / PCT_FULL;
    lvl_p = (val_pct * (PCT_FULL - sat_pct) * CHAN_MAX) / (PCT_FULL * PCT_FULL);
    lvl_q = (val_pct * (SECTOR_FULL - frac_deg * sat_pct) * CHAN_MAX) / DEN;
    lvl_t = (val_pct * (SECTOR_FULL - (SECTOR_DEG - frac_deg) * sat_pct) * CHAN_MAX) / DEN;

    case (sec)
      SEC_0: begin
        pix.red = lvl_v[7:0]; pix.green = lvl_t[7:0]; pix.blue = lvl_p[7:0];
      end
      SEC_1: begin
        pix.red = lvl_q[7:0]; pix.green = lvl_v[7:0]; pix.blue = lvl_p[7:0];
      end
      SEC_2: begin
        pix.red = lvl_p[7:0]; pix.green = lvl_v[7:0]; pix.blue = lvl_t[7:0];
      end
      SEC_3: begin
        pix.red = lvl_p[7:0]; pix.green = lvl_q[7:0]; pix.blue = lvl_v[7:0];
      end
      SEC_4: begin
        pix.red = lvl_t[7:0]; pix.green = lvl_p[7:0]; pix.blue = lvl_v[7:0];
      end
      default: begin
        pix.red = lvl_v[7:0]; pix.green = lvl_p[7:0]; pix.blue = lvl_q[7:0];
      end
    endcase
    return pix;
  endfunction

  task automatic flag_mismatch(string what, int unsigned got, int unsigned want);
    if (mismatch_count < PRINT_CAP) begin
      $display("%0t: %s: got %0d, want %0d", $time, what, got, want);
    end
    mismatch_count++;
  endtask

  // Input side: predict at every accepted transfer.
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      rgb_pending.push_back(hsv_pixel_to_rgb(in_data));
    end
  end

  // Output side: each result transfer against the oldest prediction.
  always @(posedge clk) begin
    rgb_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (rgb_pending.size() == 0) begin
        flag_mismatch("result with no pixel pending", out_data, 0);
      end else begin
        want = rgb_pending.pop_front();
        if (out_data.red != want.red) flag_mismatch("red", out_data.red, want.red);
        if (out_data.green != want.green) flag_mismatch("green", out_data.green, want.green);
        if (out_data.blue != want.blue) flag_mismatch("blue", out_data.blue, want.blue);
      end
    end
  end

  // Receiver: random stalls, or a long hold-off when the stimulus asks.
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_asks != hold_seen) begin
      hold_seen <= hold_asks;
      hold_left <= HOLD_CYCLES - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Watchdog: counts cycles with no transfer on either channel.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        stuck_cycles <= 0;
      end else if (stuck_cycles + 1 >= STUCK_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end else begin
        stuck_cycles <= stuck_cycles + 1;
      end
    end
  end

  // Offer one pixel, idling first at random; returns after its transfer.
  // in_valid is only lowered while idling, so back-to-back items keep it high.
  task automatic send_pixel(hsv_in_t px);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= px;
    do @(posedge clk); while (in_stall);
  endtask

  function automatic hsv_in_t make_pixel(int unsigned hue, int unsigned sat, int unsigned val);
    hsv_in_t px;
    px.hue        = hue[8:0];
    px.saturation = sat[6:0];
    px.brightness = val[6:0];
    return px;
  endfunction

  // Mostly legal pixels, some pinned to sector edges and percentage extremes,
  // the rest raw bits so wrap and clamp paths and every bit get exercised.
  function automatic hsv_in_t random_pixel();
    int unsigned pick, edge_deg;
    hsv_in_t     px;
    pick = $urandom_range(99);
    if (pick < 70) begin
      px = make_pixel($urandom_range(HUE_FULL - 1), $urandom_range(PCT_FULL),
                      $urandom_range(PCT_FULL));
    end else if (pick < 82) begin
      edge_deg = ($urandom_range(5) * SECTOR_DEG + HUE_FULL + $urandom_range(2) - 1) % HUE_FULL;
      px = make_pixel(edge_deg, $urandom_range(1) ? PCT_FULL - $urandom_range(1)
                                                  : $urandom_range(1),
                      $urandom_range(1) ? PCT_FULL - $urandom_range(1) : $urandom_range(1));
    end else begin
      px = hsv_in_t'($urandom);
    end
    return px;
  endfunction

  task automatic drain_results();
    in_valid <= 1'b0;
    while (rgb_pending.size() != 0) @(posedge clk);
  endtask

  task automatic run_random(int unsigned count);
    for (int unsigned i = 0; i < count; i++) begin
      send_pixel(random_pixel());
    end
  endtask

  // Field extremes, every sector start and end, wrap and clamp cases.
  task automatic test_directed_corners();
    send_idle_pct = 11;
    recv_idle_pct <= 85;
    send_pixel(make_pixel(0, 0, 0));
    send_pixel(make_pixel(0, 100, 100));
    send_pixel(make_pixel(0, 0, 100));            // white
    send_pixel(make_pixel(0, 100, 0));            // black at full saturation
    for (int unsigned s = 0; s < 6; s++) begin
      send_pixel(make_pixel(s * SECTOR_DEG, 100, 100));
      send_pixel(make_pixel(s * SECTOR_DEG + SECTOR_DEG - 1, 100, 100));
    end
    send_pixel(make_pixel(1, 100, 100));
    send_pixel(make_pixel(200, 50, 75));
    send_pixel(make_pixel(360, 100, 100));        // hue wraps to 0
    send_pixel(make_pixel(400, 80, 90));          // acts as 40
    send_pixel(make_pixel(511, 100, 100));        // top of the hue field
    send_pixel(make_pixel(90, 101, 100));         // saturation clamps
    send_pixel(make_pixel(150, 127, 60));
    send_pixel(make_pixel(270, 70, 101));         // brightness clamps
    send_pixel(make_pixel(330, 40, 127));
    send_pixel(make_pixel(511, 127, 127));
    drain_results();
  endtask

  task automatic test_slow_receiver();
    send_idle_pct = 11;
    recv_idle_pct <= 85;
    run_random(330);
    drain_results();
  endtask

  task automatic test_slow_sender();
    send_idle_pct = 85;
    recv_idle_pct <= 11;
    run_random(330);
    drain_results();
  endtask

  task automatic test_back_to_back();
    send_idle_pct = 0;
    recv_idle_pct <= 0;
    run_random(330);
    drain_results();
  endtask

  // Receiver holds off for a long stretch while pixels keep coming, so the
  // pipe fills and must push back on the input without losing a transfer.
  task automatic test_receiver_holdoff();
    send_idle_pct = 0;
    recv_idle_pct <= 0;
    hold_asks <= hold_asks + 1;
    run_random(40);
    drain_results();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_corners();
    test_slow_receiver();
    test_slow_sender();
    test_back_to_back();
    test_receiver_holdoff();

    // Let any stray result surface before the verdict.
    repeat (PIPE_DEPTH + 4) @(posedge clk);
    if (rgb_pending.size() != 0) begin
      flag_mismatch("pixels never returned", 0, rgb_pending.size());
    end
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
